>>> src/brog_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brog_pkg
// Shared types, codes and constants of the buffer region ownership guard.
// ----------------------------------------------------------------------------
package brog_pkg;

  localparam int RegionCountDef  = 7;
  localparam int OwnerCount      = 5;
  localparam int ChannelCount    = 2;
  localparam int SlotsPerChannel = 2;

  localparam int FaultRegionShift = 16;
  localparam int FaultExpShift    = 8;

  localparam logic [2:0] ActHandoff = 3'd0;
  localparam logic [2:0] ActClear   = 3'd1;
  localparam logic [2:0] ActAppend  = 3'd2;
  localparam logic [2:0] ActSetFill = 3'd3;
  localparam logic [2:0] ActRead    = 3'd4;
  localparam logic [2:0] ActFind    = 3'd5;
  localparam logic [2:0] ActQuery   = 3'd6;

  localparam logic [2:0] StOk         = 3'd0;
  localparam logic [2:0] StParam      = 3'd1;
  localparam logic [2:0] StOwnership  = 3'd2;
  localparam logic [2:0] StUnconfig   = 3'd3;
  localparam logic [2:0] StOverrun    = 3'd4;

  localparam logic [1:0] FaultNone      = 2'd0;
  localparam logic [1:0] FaultViolation = 2'd1;
  localparam logic [1:0] FaultOverrun   = 2'd2;

  localparam logic [2:0] NoSlot = 3'd7;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  region;
    logic [2:0]  owner_from;
    logic [2:0]  owner_to;
    logic [31:0] amount;
    logic [1:0]  channel;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  region_owner;
    logic [31:0] region_used;
    logic [31:0] region_free;
    logic [2:0]  found_region;
    logic [1:0]  fault_kind;
    logic [23:0] fault_word;
    logic [31:0] violation_total;
    logic [31:0] handoff_total;
    logic [31:0] overrun_total;
  } rsp_t;

endpackage
`default_nettype wire

>>> src/buffer_region_ownership_guard.sv
`default_nettype none
// ----------------------------------------------------------------------------
// buffer_region_ownership_guard
// Owner and fill tracking for a set of buffer regions, with fault reporting.
//
//   channel   direction  handshake             payload
//   in        input      in_valid_i/in_stall_o  brog_pkg::req_t
//   out       output     out_valid_o/out_stall_i brog_pkg::rsp_t
//   cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A transaction first reads the owner and fill RAMs, then checks, writes
// back and loads the output register.
// The output register holds a result while out_stall_i is high; the
// check cycle waits until it can be loaded.
// Reset clears control state, capacities, counters and the RAM valid bits.
// ----------------------------------------------------------------------------
module buffer_region_ownership_guard #(
  parameter int REGION_COUNT = brog_pkg::RegionCountDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire brog_pkg::req_t  in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output brog_pkg::rsp_t       out_data_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [2:0]      cfg_index_i,
  input  wire logic [31:0]     cfg_data_i
);

  import brog_pkg::*;

  localparam int RIW = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic              state_q, state_d;
  req_t              req_q;
  rsp_t              out_q;
  logic              out_valid_q;

  logic [31:0]       cap_q [REGION_COUNT];
  logic [REGION_COUNT-1:0] cap_nz_q, owned_q, own_vld_q, fill_vld_q;
  logic [31:0]       viol_q, hand_q, over_q;

  logic              in_acc, out_free, commit;
  logic [RIW-1:0]    rd_idx, ridx;
  logic              in_range;
  logic [2:0]        own_rd;
  logic [31:0]       fill_rd;
  logic [2:0]        owner_cur, owner_new;
  logic [31:0]       fill_cur, fill_new, cap_cur;
  logic              own_we, fill_we;
  logic [2:0]        status;
  logic [1:0]        fkind;
  logic [23:0]       fword;
  logic              viol_inc, hand_inc, over_inc;
  logic [2:0]        found;
  logic [15:0]       avail;
  logic              from_bad, to_bad;
  logic [3:0]        slot_r;

  assign in_stall_o  = (state_q != StIdle);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign commit      = (state_q == StExec) && out_free;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rd_idx   = in_data_i.region[RIW-1:0];
  assign ridx     = req_q.region[RIW-1:0];
  assign in_range = req_q.region < 3'(REGION_COUNT);

  brog_ram #(.WIDTH(3), .DEPTH(REGION_COUNT), .AW(RIW)) u_owner_ram (
    .clk_i  (clk_i),
    .we_i   (own_we && commit),
    .waddr_i(ridx),
    .wdata_i(owner_new),
    .re_i   (in_acc),
    .raddr_i(rd_idx),
    .rdata_o(own_rd)
  );

  brog_ram #(.WIDTH(32), .DEPTH(REGION_COUNT), .AW(RIW)) u_fill_ram (
    .clk_i  (clk_i),
    .we_i   (fill_we && commit),
    .waddr_i(ridx),
    .wdata_i(fill_new),
    .re_i   (in_acc),
    .raddr_i(rd_idx),
    .rdata_o(fill_rd)
  );

  // free configured raw slot search
  always_comb begin
    avail = '0;
    avail[REGION_COUNT-1:0] = cap_nz_q & ~owned_q;
    found = NoSlot;
    slot_r = '0;
    if ({2'b00, req_q.channel} < 4'(ChannelCount)) begin
      for (int i = SlotsPerChannel - 1; i >= 0; i--) begin
        slot_r = 4'(req_q.channel) * 4'(SlotsPerChannel) + 4'(i);
        if (slot_r < 4'(REGION_COUNT) && avail[slot_r]) begin
          found = slot_r[2:0];
        end
      end
    end
  end

  always_comb begin
    owner_cur = (in_range && own_vld_q[ridx]) ? own_rd : 3'd0;
    fill_cur  = (in_range && fill_vld_q[ridx]) ? fill_rd : 32'd0;
    cap_cur   = in_range ? cap_q[ridx] : 32'd0;
    from_bad  = {1'b0, req_q.owner_from} >= 4'(OwnerCount);
    to_bad    = {1'b0, req_q.owner_to} >= 4'(OwnerCount);
    owner_new = owner_cur;
    fill_new  = fill_cur;
    own_we    = 1'b0;
    fill_we   = 1'b0;
    status    = StOk;
    fkind     = FaultNone;
    fword     = '0;
    viol_inc  = 1'b0;
    hand_inc  = 1'b0;
    over_inc  = 1'b0;
    if (req_q.action == ActFind) begin
      status = StOk;
    end else if (req_q.action == 3'd7 || !in_range) begin
      status = StParam;
    end else if (req_q.action == ActQuery) begin
      status = StOk;
    end else if (req_q.action == ActClear) begin
      if (from_bad) begin
        status = StParam;
      end else if (owner_cur != req_q.owner_from) begin
        status = StOwnership;
      end else begin
        owner_new = 3'd0;
        fill_new  = 32'd0;
        own_we    = 1'b1;
        fill_we   = 1'b1;
      end
    end else if ((req_q.action == ActHandoff && (from_bad || to_bad)) ||
                 (req_q.action == ActAppend && req_q.amount == 32'd0)) begin
      status = StParam;
    end else if (cap_cur == 32'd0) begin
      status = StUnconfig;
    end else if (owner_cur != req_q.owner_from) begin
      status = StOwnership;
    end else if (req_q.action == ActHandoff) begin
      owner_new = req_q.owner_to;
      own_we    = 1'b1;
      hand_inc  = 1'b1;
    end else if (req_q.action == ActAppend) begin
      if (cap_cur - fill_cur < req_q.amount) begin
        status = StOverrun;
      end else begin
        fill_new = fill_cur + req_q.amount;
        fill_we  = 1'b1;
      end
    end else if (req_q.action == ActSetFill) begin
      if (req_q.amount > cap_cur) begin
        status = StOverrun;
      end else begin
        fill_new = req_q.amount;
        fill_we  = 1'b1;
      end
    end
    if (status == StOwnership) begin
      viol_inc = 1'b1;
      fkind    = FaultViolation;
      fword    = (24'(req_q.region) << FaultRegionShift) |
                 (24'(req_q.owner_from) << FaultExpShift) | 24'(owner_cur);
    end else if (status == StOverrun) begin
      over_inc = 1'b1;
      fkind    = FaultOverrun;
      fword    = 24'(req_q.region);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (commit) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
    end
    if (commit) begin
      out_q.status          <= status;
      out_q.region_owner    <= in_range ? owner_new : 3'd0;
      out_q.region_used     <= in_range ? fill_new : 32'd0;
      out_q.region_free     <= in_range ? cap_cur - fill_new : 32'd0;
      out_q.found_region    <= (req_q.action == ActFind) ? found : NoSlot;
      out_q.fault_kind      <= fkind;
      out_q.fault_word      <= fword;
      out_q.violation_total <= viol_q + 32'(viol_inc);
      out_q.handoff_total   <= hand_q + 32'(hand_inc);
      out_q.overrun_total   <= over_q + 32'(over_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      cap_nz_q    <= '0;
      owned_q     <= '0;
      own_vld_q   <= '0;
      fill_vld_q  <= '0;
      viol_q      <= '0;
      hand_q      <= '0;
      over_q      <= '0;
      for (int i = 0; i < REGION_COUNT; i++) begin
        cap_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i && cfg_ready_o && cfg_index_i < 3'(REGION_COUNT)) begin
        cap_q[cfg_index_i[RIW-1:0]]      <= cfg_data_i;
        cap_nz_q[cfg_index_i[RIW-1:0]]   <= |cfg_data_i;
        fill_vld_q[cfg_index_i[RIW-1:0]] <= 1'b0;
      end
      if (commit) begin
        if (own_we) begin
          own_vld_q[ridx] <= 1'b1;
          owned_q[ridx]   <= |owner_new;
        end
        if (fill_we) begin
          fill_vld_q[ridx] <= 1'b1;
        end
        viol_q <= viol_q + 32'(viol_inc);
        hand_q <= hand_q + 32'(hand_inc);
        over_q <= over_q + 32'(over_inc);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/brog_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brog_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brog_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 7,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire
